@@ design/lud_pkg.sv @@
`timescale 1ns / 1ps
// lud_pkg: shared types, constants and the lead byte decoder for the
// lenient utf-8 decoder. Depends on nothing.

package lud_pkg;

   localparam int CpWidth   = 31;
   localparam int RemWidth  = 3;
   localparam int ContBits  = 6;
   localparam int LeadBits  = 5;
   localparam logic [RemWidth-1:0] MaxCont = 3'd5;

   // decoder state carried between bytes
   typedef struct packed {
      logic [CpWidth-1:0]  partial_value;
      logic [RemWidth-1:0] bytes_remaining;
   } state_type;

   // one result transaction
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               stray_byte;
      logic               truncated;
      logic               last_of_string;
   } result_type;

   // what a byte means when no sequence is open
   typedef struct packed {
      logic                is_lead;
      logic [LeadBits-1:0] payload;
      logic [RemWidth-1:0] count;
   } lead_type;

   // classify a lead byte of the 2- to 6-byte forms
   function automatic lead_type lead_decode(input logic [7:0] b);
      lead_type l;
      l = '0;
      unique case (b) inside
         8'b110?????: begin
            l.is_lead = 1'b1;
            l.payload = b[4:0];
            l.count   = 3'd1;
         end
         8'b1110????: begin
            l.is_lead = 1'b1;
            l.payload = {1'b0, b[3:0]};
            l.count   = 3'd2;
         end
         8'b11110???: begin
            l.is_lead = 1'b1;
            l.payload = {2'b00, b[2:0]};
            l.count   = 3'd3;
         end
         8'b111110??: begin
            l.is_lead = 1'b1;
            l.payload = {3'b000, b[1:0]};
            l.count   = 3'd4;
         end
         8'b1111110?: begin
            l.is_lead = 1'b1;
            l.payload = {4'b0000, b[0]};
            l.count   = MaxCont;
         end
         default: begin
            l = '0;
         end
      endcase
      return l;
   endfunction

endpackage

@@ design/lenient_utf8_decoder_top.sv @@
`timescale 1ns / 1ps
// lenient_utf8_decoder_top: input register, decode state and result register
// of the lenient utf-8 decoder. Depends on lud_pkg, lud_decode, lud_out_reg.
//
// Usage: one byte of a string enters per req transaction, with
// req_end_of_string on the final byte. Each rsp transaction carries one
// decoded code point with its stray, truncated and last flags. Lead bytes
// and inner continuation bytes not marked end of string give no rsp
// transaction; every byte marked end of string gives exactly one, and the
// decoder is idle after it. An accepted byte waits in the input register,
// and its result is registered in the result register after the decode step.
// Throughput: one byte per cycle while the receiver does not stall, with
// the single combinational decode step between the two registers.
// Reset clears the decode state and the valid bits of the input register
// and the result register; no transaction is pending afterwards.
// When the receiver stalls, the result is held; one more byte waits in the
// input register, and bytes that give no result keep flowing until a byte
// that needs the occupied result register arrives, then req_stall rises.

module lenient_utf8_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_code_point,
   output logic        rsp_stray_byte,
   output logic        rsp_truncated,
   output logic        rsp_last_of_string
);

   logic                in_vld_ff;
   logic                in_vld_in;
   logic [7:0]          in_byte_ff;
   logic                in_eos_ff;
   lud_pkg::state_type  state_ff;
   lud_pkg::state_type  state_next;
   logic                res_valid;
   lud_pkg::result_type res;
   lud_pkg::result_type rsp_data;
   logic                slot_free;
   logic                advance;
   logic                req_take;

   // held byte leaves when it needs no result slot or the slot is free
   assign advance   = in_vld_ff && (!res_valid || slot_free);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_string;
      end
   end

   // decode step
   lud_decode u_decode (
      .state         (state_ff),
      .data_byte     (in_byte_ff),
      .end_of_string (in_eos_ff),
      .state_next    (state_next),
      .result_valid  (res_valid),
      .result        (res)
   );

   // accumulator and remaining count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_next;
      end
   end

   // result register
   lud_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (in_vld_ff && res_valid),
      .push_data (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_code_point     = rsp_data.code_point;
   assign rsp_stray_byte     = rsp_data.stray_byte;
   assign rsp_truncated      = rsp_data.truncated;
   assign rsp_last_of_string = rsp_data.last_of_string;

`ifndef SYNTHESIS
   // a byte that ends the string leaves the decoder idle
   assert property (@(posedge clock) disable iff (reset)
      advance && in_eos_ff |=> state_ff.bytes_remaining == '0)
      else $error("decoder not idle after end of string");

   // no more continuations pending than the longest form allows
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_remaining <= lud_pkg::MaxCont)
      else $error("remaining count out of range");

   // a truncated sequence is always the end of its string and never a stray byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_last_of_string && !rsp_stray_byte)
      else $error("truncated result without end of string");

   // a byte whose result finds the register busy is held back
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && res_valid && !slot_free |=> in_vld_ff && $stable(in_byte_ff))
      else $error("held byte lost while result register busy");
`endif

endmodule

@@ design/lud_decode.sv @@
`timescale 1ns / 1ps
// lud_decode: one decode step, from the current state and one byte to the
// next state and an optional result. Depends on lud_pkg.

module lud_decode (
   input  lud_pkg::state_type  state,
   input  logic [7:0]          data_byte,
   input  logic                end_of_string,
   output lud_pkg::state_type  state_next,
   output logic                result_valid,
   output lud_pkg::result_type result
);

   lud_pkg::lead_type              lead;
   logic [lud_pkg::CpWidth-1:0]    appended;
   logic [lud_pkg::RemWidth-1:0]   rem_dec;
   logic [lud_pkg::CpWidth-1:0]    lead_value;

   assign lead       = lud_pkg::lead_decode(data_byte);
   assign appended   = {state.partial_value[lud_pkg::CpWidth-lud_pkg::ContBits-1:0],
                        data_byte[lud_pkg::ContBits-1:0]};
   assign rem_dec    = state.bytes_remaining - 3'd1;
   assign lead_value = {{(lud_pkg::CpWidth-lud_pkg::LeadBits){1'b0}}, lead.payload};

   // step the accumulator
   always_comb begin
      state_next   = state;
      result_valid = 1'b0;
      result       = '0;
      if (state.bytes_remaining != '0) begin
         // continuation, top bits ignored
         if (rem_dec == '0) begin
            result_valid          = 1'b1;
            result.code_point     = appended;
            result.last_of_string = end_of_string;
            state_next            = '0;
         end else if (end_of_string) begin
            result_valid          = 1'b1;
            result.code_point     = appended;
            result.truncated      = 1'b1;
            result.last_of_string = 1'b1;
            state_next            = '0;
         end else begin
            state_next.partial_value   = appended;
            state_next.bytes_remaining = rem_dec;
         end
      end else if (!data_byte[7]) begin
         // plain ascii
         result_valid          = 1'b1;
         result.code_point     = {{(lud_pkg::CpWidth-8){1'b0}}, data_byte};
         result.last_of_string = end_of_string;
      end else if (lead.is_lead) begin
         if (end_of_string) begin
            result_valid          = 1'b1;
            result.code_point     = lead_value;
            result.truncated      = 1'b1;
            result.last_of_string = 1'b1;
            state_next            = '0;
         end else begin
            state_next.partial_value   = lead_value;
            state_next.bytes_remaining = lead.count;
         end
      end else begin
         // stray byte passed through raw
         result_valid          = 1'b1;
         result.code_point     = {{(lud_pkg::CpWidth-8){1'b0}}, data_byte};
         result.stray_byte     = 1'b1;
         result.last_of_string = end_of_string;
      end
   end

endmodule

@@ design/lud_out_reg.sv @@
`timescale 1ns / 1ps
// lud_out_reg: result register of the decoder, holds a transaction while
// the receiver stalls. Depends on lud_pkg.

module lud_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lud_pkg::result_type push_data,
   output logic                slot_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lud_pkg::result_type rsp_data
);

   logic                vld_ff;
   logic                vld_in;
   lud_pkg::result_type data_ff;

   // slot opens when empty or when the held transaction leaves this cycle
   assign slot_free = !vld_ff || !rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      if (push && slot_free) begin
         vld_in = 1'b1;
      end else if (!rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload loads only into a free slot
   always_ff @(posedge clock) begin
      if (push && slot_free) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule
